// ===== rtl/core/bcd_pkg.sv =====
package bcd_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int KEY_W   = 40;
    localparam int CNT_W   = 8;
    localparam int STAMP_W = 32;
    localparam int SEL_W   = 5;

    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic [1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PIN     = 2'd2;
    localparam logic [1:0] ACT_UNPIN   = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CNT_W-1:0]   cnt;
        logic [STAMP_W-1:0] stamp;
        logic               filled;
    } entry_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         device_id;
        logic [31:0]        block_number;
        logic [SEL_W-1:0]   entry_sel;
        logic [STAMP_W-1:0] time_now;
    } item_t;

    typedef struct packed {
        logic [SEL_W-1:0] entry_index;
        logic             needs_read;
        logic             was_hit;
        logic             no_free_entry;
        logic             count_error;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

endpackage

// ===== rtl/core/bcd_dir_ram.sv =====
module bcd_dir_ram (
    input  logic             aclk,
    input  logic             aresetn,
    input  bcd_pkg::ram_rd_t rd,
    output bcd_pkg::entry_t  rd_data,
    input  bcd_pkg::ram_wr_t wr
);

    bcd_pkg::entry_t entry_mem [bcd_pkg::ENTRIES];

    logic [bcd_pkg::ENTRIES-1:0] valid_reg;
    logic                        rd_valid_reg;
    bcd_pkg::entry_t             data_reg;

    // an entry never written reads as its reset value, all zero
    assign rd_data = rd_valid_reg ? data_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            data_reg <= entry_mem[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

endmodule

// ===== rtl/core/bcd_ctrl.sv =====
module bcd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bcd_pkg::item_t   in_item,
    output bcd_pkg::ram_rd_t rd,
    input  bcd_pkg::entry_t  rd_data,
    output bcd_pkg::ram_wr_t wr,
    output logic             res_valid,
    input  logic             res_ready,
    output bcd_pkg::res_t    res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;
    localparam logic [1:0] ST_OP   = 2'd3;

    localparam logic [bcd_pkg::IDX_W-1:0] LAST_IDX = bcd_pkg::IDX_W'(bcd_pkg::ENTRIES - 1);

    logic [1:0]                        state_reg, state_next;
    logic [1:0]                        act_reg, act_next;
    logic [bcd_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [bcd_pkg::SEL_W-1:0]         sel_reg, sel_next;
    logic [bcd_pkg::STAMP_W-1:0]       now_reg, now_next;
    logic [bcd_pkg::IDX_W-1:0]         cnt_reg, cnt_next;
    logic                              found_reg, found_next;
    logic [bcd_pkg::IDX_W-1:0]         match_idx_reg, match_idx_next;
    bcd_pkg::entry_t                   match_ent_reg, match_ent_next;
    logic                              any_reg, any_next;
    logic [bcd_pkg::IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [bcd_pkg::STAMP_W-1:0]       best_reg, best_next;

    logic                              key_eq;
    logic                              is_free;
    logic                              sel_in_range;
    bcd_pkg::entry_t                   upd;

    assign in_ready     = (state_reg == ST_IDLE);
    assign key_eq       = (rd_data.key == key_reg);
    assign is_free      = (rd_data.cnt == '0) && (rd_data.stamp <= best_reg);
    assign sel_in_range = ({27'd0, sel_reg} < 32'(bcd_pkg::ENTRIES));

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        sel_next       = sel_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        match_ent_next = match_ent_reg;
        any_next       = any_reg;
        free_idx_next  = free_idx_reg;
        best_next      = best_reg;
        rd             = '0;
        wr             = '0;
        res_valid      = 1'b0;
        res            = '0;
        upd            = rd_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    act_next   = in_item.action;
                    key_next   = {in_item.device_id, in_item.block_number};
                    sel_next   = in_item.entry_sel;
                    now_next   = in_item.time_now;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    any_next   = 1'b0;
                    best_next  = bcd_pkg::STAMP_MAX;
                    rd.en      = 1'b1;
                    if (in_item.action == bcd_pkg::ACT_LOOKUP) begin
                        rd.addr    = '0;
                        state_next = ST_SCAN;
                    end else begin
                        rd.addr    = bcd_pkg::IDX_W'(in_item.entry_sel);
                        state_next = ST_OP;
                    end
                end
            end
            ST_SCAN: begin
                // later matches and equal stamps win: highest index takes ties
                if (key_eq) begin
                    found_next     = 1'b1;
                    match_idx_next = cnt_reg;
                    match_ent_next = rd_data;
                end
                if (is_free) begin
                    any_next      = 1'b1;
                    free_idx_next = cnt_reg;
                    best_next     = rd_data.stamp;
                end
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_WB;
                end else begin
                    rd.en    = 1'b1;
                    rd.addr  = cnt_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WB: begin
                res_valid = 1'b1;
                if (found_reg) begin
                    upd        = match_ent_reg;
                    upd.filled = 1'b1;
                    if (match_ent_reg.cnt == bcd_pkg::COUNT_MAX) begin
                        res.count_error = 1'b1;
                    end else begin
                        upd.cnt = match_ent_reg.cnt + 1'b1;
                    end
                    wr.en           = res_ready;
                    wr.addr         = match_idx_reg;
                    wr.data         = upd;
                    res.entry_index = bcd_pkg::SEL_W'(match_idx_reg);
                    res.needs_read  = !match_ent_reg.filled;
                    res.was_hit     = 1'b1;
                end else if (any_reg) begin
                    upd.key    = key_reg;
                    upd.cnt    = bcd_pkg::CNT_W'(1);
                    upd.stamp  = best_reg;
                    upd.filled = 1'b1;
                    wr.en           = res_ready;
                    wr.addr         = free_idx_reg;
                    wr.data         = upd;
                    res.entry_index = bcd_pkg::SEL_W'(free_idx_reg);
                    res.needs_read  = 1'b1;
                end else begin
                    res.no_free_entry = 1'b1;
                end
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OP: begin
                res_valid       = 1'b1;
                res.entry_index = sel_reg;
                if (sel_in_range) begin
                    unique case (act_reg)
                        bcd_pkg::ACT_PIN: begin
                            if (rd_data.cnt == bcd_pkg::COUNT_MAX) begin
                                res.count_error = 1'b1;
                            end else begin
                                upd.cnt = rd_data.cnt + 1'b1;
                            end
                        end
                        bcd_pkg::ACT_RELEASE, bcd_pkg::ACT_UNPIN: begin
                            if (rd_data.cnt == '0) begin
                                res.count_error = 1'b1;
                            end else begin
                                upd.cnt = rd_data.cnt - 1'b1;
                            end
                            if (act_reg == bcd_pkg::ACT_RELEASE) begin
                                upd.stamp = now_reg;
                            end
                        end
                        default: begin
                            upd = rd_data;
                        end
                    endcase
                    wr.en   = res_ready;
                    wr.addr = bcd_pkg::IDX_W'(sel_reg);
                    wr.data = upd;
                end
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        sel_reg       <= sel_next;
        now_reg       <= now_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        match_idx_reg <= match_idx_next;
        match_ent_reg <= match_ent_next;
        any_reg       <= any_next;
        free_idx_reg  <= free_idx_next;
        best_reg      <= best_next;
    end

endmodule

// ===== rtl/core/block_cache_directory_lru.sv =====
// Channel | Dir | Beat contents
// s_      | in  | tuser: action[1:0]; tdata: device_id, block_number, entry_sel, time_now
// m_      | out | tdata: entry_index, needs_read, was_hit, no_free_entry, count_error
//
// Lookup: accept, 32 entry reads through the directory RAM's single
// read port, one write-back. Release, pin, unpin: accept with the read
// issued, then update and write-back. The RAM read port paces the scan at one
// entry per cycle.
// Reset (aresetn low, synchronous) clears the entry valid bits at once; no clearing pass.
// A full result register takes the next beat only once m_tready frees it; s_tready
// is high whenever the sequencer is idle, even with a result still waiting.
module block_cache_directory_lru (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // device_id[7:0], block_number[39:8], entry_sel[44:40],
                                  // time_now[76:45], zero[79:77]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // entry_index[4:0], needs_read[5], was_hit[6],
                                  // no_free_entry[7], count_error[8], zero[15:9]
);

    bcd_pkg::item_t   in_item;
    bcd_pkg::ram_rd_t rd;
    bcd_pkg::ram_wr_t wr;
    bcd_pkg::entry_t  rd_data;
    bcd_pkg::res_t    res;
    logic             res_valid;
    logic             res_ready;

    bcd_pkg::res_t    out_reg;
    logic             out_full_reg;

    assign in_item.action       = s_tuser;
    assign in_item.device_id    = s_tdata[7:0];
    assign in_item.block_number = s_tdata[39:8];
    assign in_item.entry_sel    = s_tdata[44:40];
    assign in_item.time_now     = s_tdata[76:45];

    bcd_dir_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .rd_data (rd_data),
        .wr      (wr)
    );

    bcd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .rd        (rd),
        .rd_data   (rd_data),
        .wr        (wr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_full_reg || m_tready;
    assign m_tvalid  = out_full_reg;
    assign m_tdata   = {7'd0, out_reg.count_error, out_reg.no_free_entry, out_reg.was_hit,
                        out_reg.needs_read, out_reg.entry_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_full_reg <= 1'b1;
        end else if (m_tready) begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    // the RAM is only written while the sequencer is busy
    assert property (@(posedge aclk) disable iff (!aresetn) wr.en |-> !s_tready)
        else $error("directory written while idle");

    // a lookup without a free entry grants nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[6:0] == 7'd0 && !m_tdata[8]))
        else $error("no_free_entry beat carries a grant");

    // a result is only handed over as the sequencer returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> s_tready)
        else $error("sequencer busy after result");

    // never read and write one entry in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd.en && wr.addr == rd.addr) |-> 1'b0)
        else $error("read and write of one entry in the same cycle");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;  // device_id, block_number, entry_sel, time_now, zero pad
    logic [1:0]  s_tuser  = '0;  // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // entry_index, needs_read, was_hit, no_free_entry,
                                 // count_error, zero pad

    block_cache_directory_lru u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow directory, advanced once per accepted beat
    logic [bcd_pkg::KEY_W-1:0]   dir_key    [bcd_pkg::ENTRIES];
    logic [bcd_pkg::CNT_W-1:0]   dir_cnt    [bcd_pkg::ENTRIES];
    logic [bcd_pkg::STAMP_W-1:0] dir_stamp  [bcd_pkg::ENTRIES];
    logic                        dir_filled [bcd_pkg::ENTRIES];

    bcd_pkg::item_t ops_to_send [$];
    bcd_pkg::res_t  grants_due  [$];
    int unsigned n_queued  = 0;
    int unsigned n_sent    = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail    = 0;
    int unsigned n_hits    = 0;
    int unsigned n_fills   = 0;
    int unsigned n_refused = 0;
    int unsigned n_sat     = 0;
    int unsigned gap_left  = 0;
    int unsigned stall_left = 0;
    logic [31:0] clock_ticks = '0;

    initial begin
        for (int i = 0; i < bcd_pkg::ENTRIES; i++) begin
            dir_key[i]    = '0;
            dir_cnt[i]    = '0;
            dir_stamp[i]  = '0;
            dir_filled[i] = 1'b0;
        end
    end

    function automatic bcd_pkg::res_t apply_directory_op(bcd_pkg::item_t op);
        bcd_pkg::res_t               r;
        logic [bcd_pkg::KEY_W-1:0]   key;
        logic [bcd_pkg::STAMP_W-1:0] oldest;
        bit                          found;
        bit                          got_free;
        int                          pick;
        r        = '0;
        key      = {op.device_id, op.block_number};
        found    = 1'b0;
        got_free = 1'b0;
        pick     = 0;
        if (op.action == bcd_pkg::ACT_LOOKUP) begin
            // duplicate keys resolve to the highest index
            for (int i = 0; i < bcd_pkg::ENTRIES; i++)
                if (dir_key[i] == key) begin
                    found = 1'b1;
                    pick  = i;
                end
            if (found) begin
                r.was_hit = 1'b1;
                if (dir_cnt[pick] == bcd_pkg::COUNT_MAX)
                    r.count_error = 1'b1;
                else
                    dir_cnt[pick] = dir_cnt[pick] + 1'b1;
            end else begin
                // oldest free entry, ties to the highest index
                oldest = bcd_pkg::STAMP_MAX;
                for (int i = 0; i < bcd_pkg::ENTRIES; i++)
                    if (dir_cnt[i] == 0 && dir_stamp[i] <= oldest) begin
                        oldest   = dir_stamp[i];
                        pick     = i;
                        got_free = 1'b1;
                    end
                if (got_free) begin
                    dir_key[pick]    = key;
                    dir_cnt[pick]    = bcd_pkg::CNT_W'(1);
                    dir_filled[pick] = 1'b0;
                end else begin
                    r.no_free_entry = 1'b1;
                end
            end
            if (found || got_free) begin
                r.entry_index    = bcd_pkg::SEL_W'(pick);
                r.needs_read     = !dir_filled[pick];
                dir_filled[pick] = 1'b1;
            end
        end else begin
            r.entry_index = op.entry_sel;
            pick          = int'(op.entry_sel);
            if (pick < bcd_pkg::ENTRIES) begin
                if (op.action == bcd_pkg::ACT_PIN) begin
                    if (dir_cnt[pick] == bcd_pkg::COUNT_MAX)
                        r.count_error = 1'b1;
                    else
                        dir_cnt[pick] = dir_cnt[pick] + 1'b1;
                end else begin
                    if (dir_cnt[pick] == 0)
                        r.count_error = 1'b1;
                    else
                        dir_cnt[pick] = dir_cnt[pick] - 1'b1;
                    if (op.action == bcd_pkg::ACT_RELEASE)
                        dir_stamp[pick] = op.time_now;
                end
            end
        end
        return r;
    endfunction

    // Source: hold a beat until taken, then idle for the drawn gap
    always @(posedge aclk) begin : source
        bcd_pkg::item_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (ops_to_send.size() != 0) begin
                op = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= op.action;
                s_tdata  <= {3'b000, op.time_now, op.entry_sel, op.block_number, op.device_id};
                n_sent   <= n_sent + 1;
                gap_left <= (((n_sent / 120) % 4) == 3) ? 0 : $urandom_range(0, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: after each beat taken, stall for the drawn number of cycles
    always @(posedge aclk) begin : sink
        int unsigned stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            stall      = (((n_checked / 120) % 4) == 1) ? 0 : $urandom_range(0, 7);
            m_tready   <= (stall == 0);
            stall_left <= stall;
        end else if (stall_left != 0) begin
            m_tready   <= (stall_left == 1);
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        bcd_pkg::item_t op;
        bcd_pkg::res_t  got;
        bcd_pkg::res_t  want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                op.action       = s_tuser;
                op.device_id    = s_tdata[7:0];
                op.block_number = s_tdata[39:8];
                op.entry_sel    = s_tdata[44:40];
                op.time_now     = s_tdata[76:45];
                grants_due.push_back(apply_directory_op(op));
            end
            if (m_tvalid && m_tready) begin
                got.entry_index   = m_tdata[4:0];
                got.needs_read    = m_tdata[5];
                got.was_hit       = m_tdata[6];
                got.no_free_entry = m_tdata[7];
                got.count_error   = m_tdata[8];
                n_checked <= n_checked + 1;
                if (grants_due.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = grants_due.pop_front();
                    if (want.was_hit) n_hits++;
                    if (want.needs_read && !want.was_hit) n_fills++;
                    if (want.no_free_entry) n_refused++;
                    if (want.count_error) n_sat++;
                    if (got.entry_index !== want.entry_index) begin
                        n_fail++;
                        $display("%0t: entry_index expected %0d, got %0d",
                                 $time, want.entry_index, got.entry_index);
                    end
                    if (got.needs_read !== want.needs_read) begin
                        n_fail++;
                        $display("%0t: needs_read expected %0d, got %0d",
                                 $time, want.needs_read, got.needs_read);
                    end
                    if (got.was_hit !== want.was_hit) begin
                        n_fail++;
                        $display("%0t: was_hit expected %0d, got %0d",
                                 $time, want.was_hit, got.was_hit);
                    end
                    if (got.no_free_entry !== want.no_free_entry) begin
                        n_fail++;
                        $display("%0t: no_free_entry expected %0d, got %0d",
                                 $time, want.no_free_entry, got.no_free_entry);
                    end
                    if (got.count_error !== want.count_error) begin
                        n_fail++;
                        $display("%0t: count_error expected %0d, got %0d",
                                 $time, want.count_error, got.count_error);
                    end
                end
            end
        end
    end

    task automatic queue_op(logic [1:0] act, logic [bcd_pkg::KEY_W-1:0] key,
                            int unsigned sel, logic [31:0] now);
        bcd_pkg::item_t op;
        op.action       = act;
        op.device_id    = key[39:32];
        op.block_number = key[31:0];
        op.entry_sel    = sel[4:0];
        op.time_now     = now;
        ops_to_send.push_back(op);
        n_queued++;
    endtask

    // Wait until every queued beat has been accepted, so the shadow state is current
    task automatic settle();
        @(negedge aclk);
        while (ops_to_send.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    function automatic logic [bcd_pkg::KEY_W-1:0] fresh_key();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        return {a[7:0], b};
    endfunction

    function automatic logic [31:0] next_tick();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = $urandom;
            default: begin
                clock_ticks = clock_ticks + $urandom_range(1, 500);
                v = clock_ticks;
            end
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [bcd_pkg::KEY_W-1:0] key_pool [40];
        logic [bcd_pkg::KEY_W-1:0] k;
        int unsigned               held [$];
        int unsigned               n;
        int unsigned               sel;
        int unsigned               roll;
        int                        e;
        bit                        sat_done;
        sat_done = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {8'h00, 32'hFFFF_FFFF};
        key_pool[3] = {8'hFF, 32'h0000_0000};
        for (int i = 4; i < 40; i++)
            key_pool[i] = (i < 12) ? {8'h01, 24'h0, i[7:0]} : fresh_key();

        // Directed: zero-key hits after reset, extremes, underflow, tie-breaks
        queue_op(bcd_pkg::ACT_LOOKUP,  '0, 31, '1);
        queue_op(bcd_pkg::ACT_LOOKUP,  '0, 0, '0);
        queue_op(bcd_pkg::ACT_LOOKUP,  '1, 0, '0);
        queue_op(bcd_pkg::ACT_RELEASE, '1, 31, '1);
        queue_op(bcd_pkg::ACT_RELEASE, '0, 31, '0);
        queue_op(bcd_pkg::ACT_RELEASE, '1, 31, 32'h1234_5678);
        queue_op(bcd_pkg::ACT_UNPIN,   '0, 0, '0);
        queue_op(bcd_pkg::ACT_PIN,     '1, 0, '1);
        queue_op(bcd_pkg::ACT_UNPIN,   '1, 0, '1);
        queue_op(bcd_pkg::ACT_PIN,     '1, 31, '1);
        queue_op(bcd_pkg::ACT_UNPIN,   '0, 31, '0);
        queue_op(bcd_pkg::ACT_RELEASE, '0, 30, '1);
        queue_op(bcd_pkg::ACT_LOOKUP,  {8'hA5, 32'h5A5A_5A5A}, 31, '1);
        queue_op(bcd_pkg::ACT_LOOKUP,  '0, 0, '0);
        queue_op(bcd_pkg::ACT_LOOKUP,  {8'h00, 32'hFFFF_FFFF}, 0, '0);
        queue_op(bcd_pkg::ACT_LOOKUP,  {8'hFF, 32'h0000_0000}, 0, '0);
        queue_op(bcd_pkg::ACT_LOOKUP,  {8'hA5, 32'h5A5A_5A5A}, 0, '0);
        queue_op(bcd_pkg::ACT_RELEASE, '0, 29, 32'd1);
        queue_op(bcd_pkg::ACT_PIN,     '0, 15, '0);
        queue_op(bcd_pkg::ACT_UNPIN,   '0, 15, '0);
        queue_op(bcd_pkg::ACT_UNPIN,   '0, 15, '0);
        queue_op(bcd_pkg::ACT_LOOKUP,  '0, 0, '0);
        queue_op(bcd_pkg::ACT_RELEASE, '0, 31, '0);

        while (n_queued < 1275) begin
            if (!sat_done && n_queued > 400) begin
                // Drive one entry to both count limits
                k = fresh_key();
                queue_op(bcd_pkg::ACT_LOOKUP, k, $urandom_range(0, 31), next_tick());
                settle();
                e = -1;
                for (int i = 0; i < bcd_pkg::ENTRIES; i++)
                    if (dir_key[i] == k) e = i;
                if (e >= 0) begin
                    sat_done = 1'b1;
                    n = (dir_cnt[e] < 254) ? 254 - dir_cnt[e] : 0;
                    repeat (n) queue_op(bcd_pkg::ACT_PIN, fresh_key(), e, next_tick());
                    queue_op(bcd_pkg::ACT_LOOKUP, k, $urandom_range(0, 31), next_tick());
                    queue_op(bcd_pkg::ACT_LOOKUP, k, $urandom_range(0, 31), next_tick());
                    queue_op(bcd_pkg::ACT_PIN, fresh_key(), e, next_tick());
                    repeat (255) queue_op(bcd_pkg::ACT_UNPIN, fresh_key(), e, next_tick());
                    queue_op(bcd_pkg::ACT_UNPIN, fresh_key(), e, next_tick());
                    queue_op(bcd_pkg::ACT_RELEASE, fresh_key(), e, next_tick());
                end
            end else begin
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    // Noise: any action, any field
                    repeat (15)
                        queue_op(2'($urandom_range(0, 3)), fresh_key(),
                                 $urandom_range(0, 31), $urandom);
                end else if (roll <= 2) begin
                    // Fill every entry until lookups are refused, then hand them back
                    settle();
                    n = $urandom_range(33, 40);
                    repeat (n)
                        queue_op(bcd_pkg::ACT_LOOKUP, fresh_key(), $urandom_range(0, 31),
                                 next_tick());
                    settle();
                    sel = $urandom_range(0, 31);
                    for (int i = 0; i < bcd_pkg::ENTRIES; i++)
                        queue_op(bcd_pkg::ACT_RELEASE, fresh_key(),
                                 (sel + i) % bcd_pkg::ENTRIES, next_tick());
                    settle();
                    for (int i = 0; i < bcd_pkg::ENTRIES; i++) begin
                        n = (dir_cnt[i] > 4) ? 4 : dir_cnt[i];
                        repeat (n)
                            queue_op($urandom_range(0, 1) ? bcd_pkg::ACT_RELEASE
                                                          : bcd_pkg::ACT_UNPIN,
                                     fresh_key(), i, next_tick());
                    end
                end else begin
                    // Mixed traffic over a small key set; release mostly held entries
                    settle();
                    held.delete();
                    for (int i = 0; i < bcd_pkg::ENTRIES; i++)
                        if (dir_cnt[i] != 0) held.push_back(i);
                    n = $urandom_range(24, 40);
                    repeat (n) begin
                        roll = $urandom_range(0, 99);
                        sel = (held.size() != 0 && $urandom_range(0, 4) != 0) ?
                              held[$urandom_range(0, held.size() - 1)] :
                              $urandom_range(0, 31);
                        if (roll < 45)
                            queue_op(bcd_pkg::ACT_LOOKUP, key_pool[$urandom_range(0, 39)],
                                     $urandom_range(0, 31), next_tick());
                        else if (roll < 75)
                            queue_op(bcd_pkg::ACT_RELEASE, fresh_key(), sel, next_tick());
                        else if (roll < 87)
                            queue_op(bcd_pkg::ACT_UNPIN, fresh_key(), sel, next_tick());
                        else
                            queue_op(bcd_pkg::ACT_PIN, fresh_key(), $urandom_range(0, 31),
                                     next_tick());
                    end
                end
            end
        end

        @(negedge aclk);
        while (ops_to_send.size() != 0 || s_tvalid || grants_due.size() != 0)
            @(negedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d beats, checked %0d results: %0d hits, %0d new fills,",
                 n_sent, n_checked, n_hits, n_fills);
        $display("%0d refusals with every entry held, %0d saturated count updates, %0d errors.",
                 n_refused, n_sat, n_fail);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d results outstanding", grants_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bcd_pkg.sv
rtl/core/bcd_dir_ram.sv
rtl/core/bcd_ctrl.sv
rtl/core/block_cache_directory_lru.sv
bench/tb.sv
